@@ rtl/pbc_pkg.sv @@
// Package with the widths, codes and reset values of the peaking biquad cascade.
`timescale 1ns / 1ps

package pbc_pkg;

  localparam int NUM_STAGES      = 8;
  localparam int SAMPLE_W        = 24;
  localparam int COEF_W          = 32;
  localparam int COEF_FRAC       = 24;
  localparam int GUARD_BITS      = 8;
  localparam int HEAD_BITS       = 8;
  localparam int CFG_W           = 4;
  localparam int COEFS_PER_STAGE = 6;

  localparam int STG_SEL_W  = 3;
  localparam int COEF_SEL_W = 3;

  localparam int STG_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int CNT_W = $clog2(NUM_STAGES + 1);

  localparam int MUL_W  = COEF_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int TERM_SH = COEF_FRAC - GUARD_BITS;
  localparam int ACC_W  = MUL_W + SAMPLE_W - TERM_SH + 4;
  localparam int T_W    = SAMPLE_W + HEAD_BITS;

  localparam logic MODE_FILTER = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  typedef enum logic [COEF_SEL_W-1:0] {
    COEF_A0 = 3'd0,
    COEF_A1 = 3'd1,
    COEF_A2 = 3'd2,
    COEF_R  = 3'd3,
    COEF_C1 = 3'd4,
    COEF_C2 = 3'd5
  } coef_sel_t;

  typedef enum logic [1:0] {
    HIST_X1 = 2'd0,
    HIST_X2 = 2'd1,
    HIST_Y1 = 2'd2,
    HIST_Y2 = 2'd3
  } hist_sel_t;

  // Pass-through value of a coefficient slot that has never been written.
  function automatic logic signed [COEF_W-1:0] coef_reset_value(input logic [COEF_SEL_W-1:0] sel);
    logic signed [COEF_W-1:0] v;
    v = '0;
    if (sel == COEF_A0 || sel == COEF_R) begin
      v = COEF_W'(64'd1 << COEF_FRAC);
    end
    return v;
  endfunction

endpackage

@@ rtl/peaking_biquad_cascade_core.sv @@
// Top level of the peaking biquad cascade: sequencer, shared multiplier and state memories.
`timescale 1ns / 1ps

// Flow: a filter transaction runs the n active sections in turn, n being stages_in_use
//   clipped to NUM_STAGES, on the single shared 32x32 multiplier and the one read port of
//   each memory; n = 0 goes straight to the flush state. No new transaction is accepted until
//   the result is loaded into the output register. Coefficient writes leave the block idle.
// Reset: rst_n is synchronous, active low; stages_in_use returns to 1, all coefficients read
//   as pass-through and all history reads as zero at once, through per-entry valid bits.
module peaking_biquad_cascade_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic [pbc_pkg::CFG_W-1:0]               cfg_wr_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_mode,
  input  logic signed [pbc_pkg::SAMPLE_W-1:0]     in_sample_in,
  input  logic [pbc_pkg::STG_SEL_W-1:0]           in_stage_select,
  input  logic [pbc_pkg::COEF_SEL_W-1:0]          in_coef_select,
  input  logic signed [pbc_pkg::COEF_W-1:0]       in_coef_value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [pbc_pkg::SAMPLE_W-1:0]     out_sample_out
);
  import pbc_pkg::*;

  // Each section runs a fixed ten-step schedule. Steps 0 to 5 issue memory reads
  // (five products, then the reciprocal). The registered read data of product step k is
  // multiplied in step k+1 and accumulated in step k+2. Step 7 rounds and saturates
  // the sum, step 8 multiplies by r, step 9 produces the section output.
  localparam logic [3:0] STEP_FIRST     = 4'd0;
  localparam logic [3:0] STEP_MUL_X     = 4'd1;
  localparam logic [3:0] STEP_ACC_FIRST = 4'd2;
  localparam logic [3:0] STEP_WR_X2     = 4'd3;
  localparam logic [3:0] STEP_WR_X1     = 4'd4;
  localparam logic [3:0] STEP_WR_Y2     = 4'd5;
  localparam logic [3:0] STEP_ACC_LAST  = 4'd6;
  localparam logic [3:0] STEP_SUM       = 4'd7;
  localparam logic [3:0] STEP_MUL_R     = 4'd8;
  localparam logic [3:0] STEP_OUT       = 4'd9;

  localparam int CADDR_W = STG_W + COEF_SEL_W;
  localparam int HADDR_W = STG_W + 2;
  localparam int COEF_DEPTH = 2 ** CADDR_W;
  localparam int HIST_DEPTH = 2 ** HADDR_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH
  } state_t;

  state_t                     state_r;
  logic [3:0]                 step_r;
  logic [STG_W-1:0]           stage_r;
  logic [CNT_W-1:0]           n_r;
  logic [CFG_W-1:0]           stages_in_use_r;
  logic signed [SAMPLE_W-1:0] v_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  // Coefficient memory: eight slots per section, six used.
  logic signed [COEF_W-1:0]   coef_mem [COEF_DEPTH];
  logic [COEF_DEPTH-1:0]      coef_vld_r;
  logic signed [COEF_W-1:0]   coef_rd_r;
  logic                       coef_rd_vld_r;
  logic [COEF_SEL_W-1:0]      coef_rd_sel_r;
  logic [CADDR_W-1:0]         coef_raddr;
  logic                       coef_we;
  logic [CADDR_W-1:0]         coef_waddr;

  // History memory: x1, x2, y1, y2 per section.
  logic signed [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0]      hist_vld_r;
  logic signed [SAMPLE_W-1:0] hist_rd_r;
  logic                       hist_rd_vld_r;
  logic [HADDR_W-1:0]         hist_raddr;
  logic                       hist_we;
  logic [HADDR_W-1:0]         hist_waddr;
  logic signed [SAMPLE_W-1:0] hist_wdata;

  logic [COEF_SEL_W-1:0]      csel;
  hist_sel_t                  hsel_rd;
  hist_sel_t                  hsel_wr;

  logic signed [COEF_W-1:0]   coef_eff;
  logic signed [SAMPLE_W-1:0] hist_eff;

  // Datapath registers.
  logic signed [MUL_W-1:0]    mul_a;
  logic signed [MUL_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    acc_nxt;
  logic signed [ACC_W-1:0]    term;
  logic signed [PROD_W-1:0]   prod_rnd;
  logic signed [ACC_W-1:0]    acc_rnd;
  logic signed [ACC_W-GUARD_BITS-1:0] t_full;
  logic signed [T_W-1:0]      t_nxt;
  logic signed [T_W-1:0]      t_r;
  logic signed [COEF_W-1:0]   r_r;
  logic signed [SAMPLE_W-1:0] x1_r;
  logic signed [SAMPLE_W-1:0] y1_r;
  logic signed [PROD_W-1:0]   y_rnd;
  logic signed [PROD_W-COEF_FRAC-1:0] y_full;
  logic signed [SAMPLE_W-1:0] y_nxt;

  logic                       in_fire;
  logic                       out_free;
  logic                       coef_addr_ok;
  logic [7:0]                 cfg_ext;
  logic [CNT_W-1:0]           n_nxt;
  logic                       last_stage;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_sample_out = out_sample_r;

  // A coefficient write lands only on an existing section and one of its six slots.
  assign coef_addr_ok = (32'(in_stage_select) < 32'(NUM_STAGES)) &&
                        (32'(in_coef_select) < 32'(COEFS_PER_STAGE));
  assign coef_we    = in_fire && (in_mode == MODE_COEF) && coef_addr_ok;
  assign coef_waddr = {STG_W'(in_stage_select), in_coef_select};

  // Stage count is clipped to the number of sections that exist.
  assign cfg_ext = 8'(stages_in_use_r);
  assign n_nxt   = (cfg_ext > 8'(NUM_STAGES)) ? CNT_W'(NUM_STAGES) : CNT_W'(stages_in_use_r);
  assign last_stage = ((CNT_W'(stage_r) + CNT_W'(1)) == n_r);

  // Read address schedule for the current step.
  always_comb begin
    csel    = COEF_A0;
    hsel_rd = HIST_X1;
    case (step_r)
      4'd0: begin
        csel = COEF_A0;
      end
      4'd1: begin
        csel    = COEF_A1;
        hsel_rd = HIST_X1;
      end
      4'd2: begin
        csel    = COEF_A2;
        hsel_rd = HIST_X2;
      end
      4'd3: begin
        csel    = COEF_C1;
        hsel_rd = HIST_Y1;
      end
      4'd4: begin
        csel    = COEF_C2;
        hsel_rd = HIST_Y2;
      end
      4'd5: begin
        csel = COEF_R;
      end
      default: begin
        csel    = COEF_A0;
        hsel_rd = HIST_X1;
      end
    endcase
  end

  assign coef_raddr = {stage_r, csel};
  assign hist_raddr = {stage_r, hsel_rd};

  // History write schedule. Each old value is written only after it has been read
  // for this section, so the shift never loses an entry.
  always_comb begin
    hist_we    = 1'b0;
    hsel_wr    = HIST_X1;
    hist_wdata = v_r;
    if (state_r == S_RUN) begin
      case (step_r)
        STEP_WR_X2: begin
          hist_we    = 1'b1;
          hsel_wr    = HIST_X2;
          hist_wdata = x1_r;
        end
        STEP_WR_X1: begin
          hist_we    = 1'b1;
          hsel_wr    = HIST_X1;
          hist_wdata = v_r;
        end
        STEP_WR_Y2: begin
          hist_we    = 1'b1;
          hsel_wr    = HIST_Y2;
          hist_wdata = y1_r;
        end
        STEP_OUT: begin
          hist_we    = 1'b1;
          hsel_wr    = HIST_Y1;
          hist_wdata = y_nxt;
        end
        default: begin
          hist_we = 1'b0;
        end
      endcase
    end
  end

  assign hist_waddr = {stage_r, hsel_wr};

  // Memories with registered read data.
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= in_coef_value;
    end
    coef_rd_r     <= coef_mem[coef_raddr];
    coef_rd_vld_r <= coef_vld_r[coef_raddr];
    coef_rd_sel_r <= csel;
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_rd_r     <= hist_mem[hist_raddr];
    hist_rd_vld_r <= hist_vld_r[hist_raddr];
  end

  // Entries that were never written read as their reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
      hist_vld_r <= '0;
    end else begin
      if (coef_we) begin
        coef_vld_r[coef_waddr] <= 1'b1;
      end
      if (hist_we) begin
        hist_vld_r[hist_waddr] <= 1'b1;
      end
    end
  end

  assign coef_eff = coef_rd_vld_r ? coef_rd_r : coef_reset_value(coef_rd_sel_r);
  assign hist_eff = hist_rd_vld_r ? hist_rd_r : '0;

  // Shared multiplier: a coefficient times a sample for the five products,
  // then the reciprocal times the saturated sum.
  always_comb begin
    if (step_r == STEP_MUL_R) begin
      mul_a = r_r;
      mul_b = MUL_W'(t_r);
    end else if (step_r == STEP_MUL_X) begin
      mul_a = coef_eff;
      mul_b = MUL_W'(v_r);
    end else begin
      mul_a = coef_eff;
      mul_b = MUL_W'(hist_eff);
    end
  end

  // Round half away from zero: add half, less one for negative values, then drop bits.
  assign prod_rnd = prod_r + PROD_W'(64'd1 << (TERM_SH - 1)) - PROD_W'(prod_r[PROD_W-1]);
  assign term     = prod_rnd[TERM_SH +: ACC_W];
  assign acc_nxt  = ((step_r == STEP_ACC_FIRST) ? ACC_W'(0) : acc_r) + term;

  assign acc_rnd = acc_r + ACC_W'(64'd1 << (GUARD_BITS - 1)) - ACC_W'(acc_r[ACC_W-1]);
  assign t_full  = acc_rnd[ACC_W-1:GUARD_BITS];

  always_comb begin
    if (t_full[ACC_W-GUARD_BITS-1:T_W-1] == '0 || t_full[ACC_W-GUARD_BITS-1:T_W-1] == '1) begin
      t_nxt = t_full[T_W-1:0];
    end else if (t_full[ACC_W-GUARD_BITS-1]) begin
      t_nxt = {1'b1, {(T_W-1){1'b0}}};
    end else begin
      t_nxt = {1'b0, {(T_W-1){1'b1}}};
    end
  end

  assign y_rnd  = prod_r + PROD_W'(64'd1 << (COEF_FRAC - 1)) - PROD_W'(prod_r[PROD_W-1]);
  assign y_full = y_rnd[PROD_W-1:COEF_FRAC];

  always_comb begin
    if (y_full[PROD_W-COEF_FRAC-1:SAMPLE_W-1] == '0 ||
        y_full[PROD_W-COEF_FRAC-1:SAMPLE_W-1] == '1) begin
      y_nxt = y_full[SAMPLE_W-1:0];
    end else if (y_full[PROD_W-COEF_FRAC-1]) begin
      y_nxt = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_nxt = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // Datapath registers, which hold payload only and need no reset.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (step_r >= STEP_ACC_FIRST && step_r <= STEP_ACC_LAST) begin
      acc_r <= acc_nxt;
    end
    if (step_r == STEP_SUM) begin
      t_r <= t_nxt;
    end
    if (step_r == STEP_ACC_LAST) begin
      r_r <= coef_eff;
    end
    if (step_r == STEP_ACC_FIRST) begin
      x1_r <= hist_eff;
    end
    if (step_r == STEP_WR_X1) begin
      y1_r <= hist_eff;
    end
  end

  // Sequencer with the configuration register and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      step_r          <= STEP_FIRST;
      stage_r         <= '0;
      n_r             <= '0;
      stages_in_use_r <= CFG_W'(1);
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        stages_in_use_r <= cfg_wr_data;
      end
      // The output register is loaded from the flush state when free, else it
      // empties once its transaction is taken.
      if (state_r == S_FLUSH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          step_r  <= STEP_FIRST;
          stage_r <= '0;
          if (in_fire && in_mode == MODE_FILTER) begin
            v_r <= in_sample_in;
            n_r <= n_nxt;
            if (n_nxt == '0) begin
              state_r <= S_FLUSH;
            end else begin
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (step_r == STEP_OUT) begin
            v_r    <= y_nxt;
            step_r <= STEP_FIRST;
            if (last_stage) begin
              state_r <= S_FLUSH;
            end else begin
              stage_r <= stage_r + STG_W'(1);
            end
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            out_sample_r <= v_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The step counter never runs past the output step of a section.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (step_r <= STEP_OUT))
    else $error("section step counter out of range");

  // The section being processed is always one of the active sections.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (CNT_W'(stage_r) < n_r))
    else $error("section index beyond active stage count");

  // History is only written while a sample is being filtered.
  assert property (@(posedge clk) disable iff (!rst_n)
    hist_we |-> (state_r == S_RUN))
    else $error("history write outside of filtering");

  // A filtered sample is complete only after the output step of the last section.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN && step_r == STEP_OUT && last_stage) |=> (state_r == S_FLUSH))
    else $error("last section did not hand over its result");

  // A new result is loaded only when the output register is free.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH && out_valid_r && !out_ready) |=> (state_r == S_FLUSH))
    else $error("result loaded while output register was occupied");
`endif

endmodule

@@ sim/pbc_cascade_monitor.sv @@
// Monitor that mirrors the peaking biquad cascade and checks every output sample it produces.
`timescale 1ns / 1ps

module pbc_cascade_monitor (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [pbc_pkg::CFG_W-1:0]           cfg_wr_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                in_mode,
  input  logic signed [pbc_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic [pbc_pkg::STG_SEL_W-1:0]       in_stage_select,
  input  logic [pbc_pkg::COEF_SEL_W-1:0]      in_coef_select,
  input  logic signed [pbc_pkg::COEF_W-1:0]   in_coef_value,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [pbc_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                                drain_done,
  output int                                  fail_count,
  output int                                  pending_results,
  output int                                  results_checked
);

  import pbc_pkg::*;

  typedef longint unsigned mag_t;

  logic signed [COEF_W-1:0]   coef_bank [NUM_STAGES][COEFS_PER_STAGE];
  logic signed [SAMPLE_W-1:0] hist_bank [NUM_STAGES][4];
  logic [CFG_W-1:0]           stage_count;
  logic signed [SAMPLE_W-1:0] predicted_samples [$];
  bit                         leftovers_checked;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: cascade monitor: %s", $time, msg);
    fail_count++;
  endtask

  function automatic mag_t mag_of(input longint v);
    return mag_t'((v < 0) ? -v : v);
  endfunction

  // Shift right by sh bits, rounding half away from zero.
  function automatic longint round_away(input longint v, input int sh);
    mag_t m;
    m = (mag_of(v) + (mag_t'(1) << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // One second-order section, history update included.
  function automatic logic signed [SAMPLE_W-1:0] run_section(input int st,
                                                             input logic signed [SAMPLE_W-1:0] x);
    longint acc;
    longint t;
    longint rv;
    mag_t   pm;
    logic signed [SAMPLE_W-1:0] y;
    acc = round_away(longint'(coef_bank[st][COEF_A0]) * longint'(x), TERM_SH);
    acc += round_away(longint'(coef_bank[st][COEF_A1]) * longint'(hist_bank[st][HIST_X1]), TERM_SH);
    acc += round_away(longint'(coef_bank[st][COEF_A2]) * longint'(hist_bank[st][HIST_X2]), TERM_SH);
    acc += round_away(longint'(coef_bank[st][COEF_C1]) * longint'(hist_bank[st][HIST_Y1]), TERM_SH);
    acc += round_away(longint'(coef_bank[st][COEF_C2]) * longint'(hist_bank[st][HIST_Y2]), TERM_SH);
    t = clamp(round_away(acc, GUARD_BITS), T_W);
    rv = longint'(coef_bank[st][COEF_R]);
    pm = (mag_of(rv) * mag_of(t) + (mag_t'(1) << (COEF_FRAC - 1))) >> COEF_FRAC;
    rv = ((rv < 0) != (t < 0)) ? -longint'(pm) : longint'(pm);
    rv = clamp(rv, SAMPLE_W);
    y = rv[SAMPLE_W-1:0];
    hist_bank[st][HIST_X2] = hist_bank[st][HIST_X1];
    hist_bank[st][HIST_X1] = x;
    hist_bank[st][HIST_Y2] = hist_bank[st][HIST_Y1];
    hist_bank[st][HIST_Y1] = y;
    return y;
  endfunction

  task automatic clear_model();
    for (int st = 0; st < NUM_STAGES; st++) begin
      for (int cs = 0; cs < COEFS_PER_STAGE; cs++) begin
        coef_bank[st][cs] = (cs == COEF_A0 || cs == COEF_R) ? (COEF_W'(64'd1 << COEF_FRAC)) : '0;
      end
      for (int h = 0; h < 4; h++) begin
        hist_bank[st][h] = '0;
      end
    end
    stage_count = CFG_W'(1);
    predicted_samples.delete();
    leftovers_checked = 1'b0;
  endtask

  always @(posedge clk) begin : monitor_step
    logic signed [SAMPLE_W-1:0] v;
    logic signed [SAMPLE_W-1:0] want;
    int n;
    if (!rst_n) begin
      clear_model();
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_samples.size() == 0) begin
          report_mismatch($sformatf("output sample %0d with nothing pending", out_sample_out));
        end else begin
          want = predicted_samples.pop_front();
          results_checked++;
          if (out_sample_out !== want) begin
            report_mismatch($sformatf("sample_out got %0d, predicted %0d", out_sample_out, want));
          end
        end
      end
      if (cfg_wr_en) begin
        stage_count = cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        if (in_mode == MODE_COEF) begin
          if (in_stage_select < NUM_STAGES && in_coef_select < COEFS_PER_STAGE) begin
            coef_bank[in_stage_select][in_coef_select] = in_coef_value;
          end
        end else begin
          n = (stage_count > NUM_STAGES) ? NUM_STAGES : int'(stage_count);
          v = in_sample_in;
          for (int st = 0; st < n; st++) begin
            v = run_section(st, v);
          end
          predicted_samples.push_back(v);
        end
      end
      if (drain_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        while (predicted_samples.size() != 0) begin
          want = predicted_samples.pop_front();
          report_mismatch($sformatf("predicted sample %0d never came out", want));
        end
      end
    end
    pending_results = predicted_samples.size();
  end

endmodule

@@ sim/tb_peaking_biquad_cascade_core.sv @@
// Testbench top for the peaking biquad cascade: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_peaking_biquad_cascade_core;

  import pbc_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 6;
  // The watchdog limit lies many times above the longest gap between transactions: the
  // slowest filter transaction, with all sections active, plus an idle burst on each side.
  localparam int WATCHDOG_LIMIT = 4000;
  // Cycles allowed for a coefficient write or the last filter pass to finish when nothing
  // more is expected at the output.
  localparam int SETTLE_CYCLES  = 10 * NUM_STAGES + 8;
  localparam int RANDOM_ITEMS   = 800;
  localparam int PHASE_ITEMS    = 100;
  localparam int MAX_BURST      = 18;

  localparam logic [COEF_SEL_W-1:0] COEF_SEL_SPARE_LO = 3'd6;
  localparam logic [COEF_SEL_W-1:0] COEF_SEL_SPARE_HI = 3'd7;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0]   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0]   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
  localparam int                         COEF_ONE   = 1 << COEF_FRAC;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [CFG_W-1:0]           cfg_wr_data;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_mode;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic [STG_SEL_W-1:0]       in_stage_select;
  logic [COEF_SEL_W-1:0]      in_coef_select;
  logic signed [COEF_W-1:0]   in_coef_value;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       drain_done;

  int fail_count;
  int pending_results;
  int results_checked;

  // Chance, in percent, that a transaction on either side is preceded by an idle burst.
  // Zero gives stretches where both sides run flat out.
  int idle_pct;

  int item_count;
  int filter_count;
  int coef_write_count;
  int stage_setting_count;

  peaking_biquad_cascade_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_sample_in    (in_sample_in),
    .in_stage_select (in_stage_select),
    .in_coef_select  (in_coef_select),
    .in_coef_value   (in_coef_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample_out  (out_sample_out)
  );

  // The monitor sees every channel at the rising edge, keeps its own copy of the
  // coefficients and history, and counts mismatches.
  pbc_cascade_monitor u_monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_sample_in    (in_sample_in),
    .in_stage_select (in_stage_select),
    .in_coef_select  (in_coef_select),
    .in_coef_value   (in_coef_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample_out  (out_sample_out),
    .drain_done      (drain_done),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Uniform integer in [-half, half].
  function automatic int rand_span(input int half);
    return int'($urandom_range(2 * half)) - half;
  endfunction

  // Idle burst length before the next transaction, or zero for none.
  function automatic int pick_gap();
    if (idle_pct != 0 && int'($urandom_range(99)) < idle_pct) begin
      return int'($urandom_range(MAX_BURST, 1));
    end
    return 0;
  endfunction

  // Samples: full-scale extremes, quiet signal near zero, and full random words.
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(9))
      0: begin
        v = SAMPLE_MAX;
      end
      1: begin
        v = SAMPLE_MIN;
      end
      2, 3, 4: begin
        v = SAMPLE_W'(rand_span(4096));
      end
      default: begin
        v = SAMPLE_W'($urandom);
      end
    endcase
    return v;
  endfunction

  // Coefficients in the range a real peaking section would use: a0 near one, r between
  // one half and one, feedback terms moderate so most sections stay out of saturation.
  function automatic logic signed [COEF_W-1:0] sane_coef(input logic [COEF_SEL_W-1:0] sel);
    case (sel)
      COEF_A0: return COEF_ONE + rand_span(COEF_ONE / 4);
      COEF_A1: return rand_span(COEF_ONE);
      COEF_A2: return rand_span(COEF_ONE / 2);
      COEF_R:  return COEF_ONE / 2 + int'($urandom_range(COEF_ONE / 2));
      COEF_C1: return rand_span(COEF_ONE);
      default: return -int'($urandom_range(COEF_ONE / 10 * 9));
    endcase
  endfunction

  // Drives one transaction from a falling edge and returns at the falling edge after it
  // was accepted. Valid stays high into the next transaction unless a gap is drawn.
  task automatic send_item(input logic                       mode,
                           input logic signed [SAMPLE_W-1:0] smp,
                           input logic [STG_SEL_W-1:0]       stg,
                           input logic [COEF_SEL_W-1:0]      csel,
                           input logic signed [COEF_W-1:0]   val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode         <= mode;
    in_sample_in    <= smp;
    in_stage_select <= stg;
    in_coef_select  <= csel;
    in_coef_value   <= val;
    in_valid        <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Filter transaction; the unused coefficient fields carry random bits.
  task automatic filter_sample(input logic signed [SAMPLE_W-1:0] smp);
    send_item(MODE_FILTER, smp, STG_SEL_W'($urandom), COEF_SEL_W'($urandom), COEF_W'($urandom));
    filter_count++;
    item_count++;
  endtask

  // Coefficient write; writes to an unused coefficient slot change nothing and are not
  // counted as items.
  task automatic write_coef(input logic [STG_SEL_W-1:0]     stg,
                            input logic [COEF_SEL_W-1:0]    csel,
                            input logic signed [COEF_W-1:0] val);
    send_item(MODE_COEF, SAMPLE_W'($urandom), stg, csel, val);
    if (stg < NUM_STAGES && csel < COEFS_PER_STAGE) begin
      coef_write_count++;
      item_count++;
    end
  endtask

  // The stage count is only changed with the block idle: every predicted sample must have
  // come out, then a pause covers a coefficient write or filter pass still in flight.
  task automatic set_stages(input logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    stage_setting_count++;
  endtask

  // Result side: ready drops for random idle bursts drawn by pick_gap.
  initial begin : result_sink
    int stall_left;
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready  <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Watchdog: ends the run when no transaction moves on either channel for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Watchdog expired after %0d cycles without a transaction.", WATCHDOG_LIMIT);
    $display("peaking_biquad_cascade_core regression: fail");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int pick;
    logic [CFG_W-1:0] stages;
    bit last_phase;

    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_valid        = 1'b0;
    in_mode         = MODE_FILTER;
    in_sample_in    = '0;
    in_stage_select = '0;
    in_coef_select  = '0;
    in_coef_value   = '0;
    drain_done      = 1'b0;
    idle_pct        = 20;
    item_count      = 0;
    filter_count    = 0;
    coef_write_count    = 0;
    stage_setting_count = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Out of reset one pass-through section is active, so full-scale samples
    // must come back unchanged.
    filter_sample(SAMPLE_MAX);
    filter_sample(SAMPLE_MIN);
    filter_sample('0);

    // Extreme coefficients in section 0, plus writes to the two unused coefficient slots,
    // which must leave the section untouched. Full-scale input then saturates the output.
    write_coef(STG_SEL_W'(0), COEF_A0, COEF_MAX);
    write_coef(STG_SEL_W'(0), COEF_A1, COEF_MIN);
    write_coef(STG_SEL_W'(0), COEF_SEL_SPARE_LO, COEF_W'($urandom));
    write_coef(STG_SEL_W'(0), COEF_SEL_SPARE_HI, COEF_W'($urandom));
    filter_sample(SAMPLE_MAX);
    filter_sample(SAMPLE_MIN);
    filter_sample(SAMPLE_W'(-1));

    // Negative full-scale reciprocal and strong feedback drive the rescale step to its limits.
    write_coef(STG_SEL_W'(0), COEF_R, COEF_MIN);
    write_coef(STG_SEL_W'(0), COEF_C1, COEF_ONE);
    write_coef(STG_SEL_W'(0), COEF_C2, COEF_MAX);
    write_coef(STG_SEL_W'(0), COEF_A2, COEF_ONE);
    filter_sample(SAMPLE_W'(1));
    filter_sample(SAMPLE_W'(12345));

    // No active sections: the sample passes straight through and no history moves.
    set_stages('0);
    filter_sample(SAMPLE_MIN);
    filter_sample(SAMPLE_MAX);

    // A stage count above the number of sections behaves as all sections active.
    set_stages({CFG_W{1'b1}});
    write_coef(STG_SEL_W'(NUM_STAGES - 1), COEF_A0, -COEF_ONE);
    filter_sample(SAMPLE_W'(100));
    filter_sample(SAMPLE_MIN);

    // Random part, in phases. Each phase picks a stage count (the extremes recur), reloads a
    // random subset of sections with realistic coefficients, then streams mostly samples
    // mixed with single coefficient updates and some fully random writes.
    phase = 0;
    while (item_count < RANDOM_ITEMS) begin
      last_phase = (item_count + PHASE_ITEMS >= RANDOM_ITEMS);
      case (phase % 8)
        0: stages = CFG_W'(NUM_STAGES);
        1: stages = CFG_W'($urandom_range(NUM_STAGES - 1, 2));
        2: stages = {CFG_W{1'b1}};
        3: stages = '0;
        4: stages = CFG_W'(1);
        5: stages = CFG_W'($urandom_range(15, NUM_STAGES + 1));
        6: stages = CFG_W'(NUM_STAGES);
        default: stages = CFG_W'($urandom_range(NUM_STAGES, 1));
      endcase
      set_stages(stages);
      // The last phase runs with no idling on either side.
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 10;
        2: idle_pct = 35;
        default: idle_pct = 70;
      endcase
      if (last_phase) begin
        idle_pct = 0;
      end

      for (int st = 0; st < NUM_STAGES; st++) begin
        if ($urandom_range(1) == 1) begin
          for (int cs = 0; cs < COEFS_PER_STAGE; cs++) begin
            write_coef(STG_SEL_W'(st), COEF_SEL_W'(cs), sane_coef(COEF_SEL_W'(cs)));
          end
        end
      end

      repeat (PHASE_ITEMS) begin
        pick = int'($urandom_range(99));
        if (pick < 80) begin
          filter_sample(rand_sample());
        end else if (pick < 90) begin
          write_coef(STG_SEL_W'($urandom), COEF_SEL_W'($urandom_range(COEFS_PER_STAGE - 1)),
                     sane_coef(COEF_SEL_W'($urandom_range(COEFS_PER_STAGE - 1))));
        end else begin
          write_coef(STG_SEL_W'($urandom), COEF_SEL_W'($urandom), COEF_W'($urandom));
        end
      end
      phase++;
    end

    // Drain: wait for every predicted sample, then give the block time to emit anything
    // unexpected before the monitor checks for leftovers.
    in_valid <= 1'b0;
    idle_pct = 0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    drain_done <= 1'b1;
    repeat (2) @(negedge clk);

    $display("Sent %0d transactions over %0d stage-count settings: %0d samples, %0d coefficient writes.",
             item_count, stage_setting_count, filter_count, coef_write_count);
    $display("Compared %0d output samples, with %0d mismatches.", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("peaking_biquad_cascade_core regression: pass");
    end else begin
      $display("peaking_biquad_cascade_core regression: fail");
    end
    $finish;
  end

endmodule
